>>> rtl/prewitt_edge_magnitude_core_defines.svh
// ----------------------------------------------------------------------------
// Prewitt edge magnitude core - assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_CORE_DEFINES_SVH
`define PREWITT_EDGE_MAGNITUDE_CORE_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define PEM_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a condition is followed by another on the next clock edge.
`define PEM_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/pem_pkg.sv
// ----------------------------------------------------------------------------
// Prewitt edge magnitude package
// Types, codes and fixed widths shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package pem_pkg;

	localparam int PIXEL_W       = 8;
	localparam int MAG_W         = 11;
	localparam int WIDTH_REG_W   = 11;
	localparam int HEIGHT_W      = 13;
	localparam int ROW_W         = 12;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_IDX_W     = 1;
	localparam int ABS_W         = 10;
	localparam int SUM_W         = 10;
	localparam int RAD_W         = 22;
	localparam int REM_W         = 12;
	localparam int ROOT_STEPS    = 11;
	localparam int STEP_W        = 4;
	localparam int MIN_DIM       = 3;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_GRAD,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_px;
		logic update;
		logic grad;
		logic sq_x;
		logic sq_y;
		logic root_step;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic produce;
		logic root_last;
		logic out_free;
	} status_t;

endpackage

>>> rtl/pem_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pem_datapath.sv
// ----------------------------------------------------------------------------
// Prewitt edge magnitude datapath
// Config registers, raster counters, line stores, window, gradient,
// squares, bit-serial square root and the output register.
// ----------------------------------------------------------------------------
`include "prewitt_edge_magnitude_core_defines.svh"

module pem_datapath #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pem_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [pem_pkg::PIXEL_W-1:0]    pixel,
	input  pem_pkg::cmd_t                cmd,
	output pem_pkg::status_t             st,
	input  logic                         m_tready,
	output logic                         m_tvalid,
	output logic [15:0]                  m_tdata,
	output logic                         m_tlast
);

	import pem_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EWW = $clog2(MAX_WIDTH + 1);

	logic [WIDTH_REG_W-1:0] image_width_q;
	logic [HEIGHT_W-1:0]    image_height_q;
	logic [CW-1:0]          column_q;
	logic [ROW_W-1:0]       row_q;
	logic [EWW-1:0]         eff_w;
	logic [HEIGHT_W-1:0]    eff_h;
	logic [CW-1:0]          col_cur;
	logic [ROW_W-1:0]       row_cur;
	logic [EWW-1:0]         col_ext;
	logic [EWW-1:0]         col_inc;
	logic [HEIGHT_W-1:0]    row_ext;
	logic [HEIGHT_W-1:0]    row_cur_ext;
	logic [HEIGHT_W-1:0]    row_inc;
	logic                   col_wrap;
	logic                   row_wrap;
	logic                   last_c;

	logic [PIXEL_W-1:0]     pixel_q;
	logic [PIXEL_W-1:0]     upper_rd;
	logic [PIXEL_W-1:0]     middle_rd;
	logic [PIXEL_W-1:0]     win_q [3][3];
	logic                   last_q;

	logic [SUM_W-1:0]       sum_l, sum_r, sum_t, sum_b;
	logic signed [SUM_W:0]  dx, dy;
	logic [ABS_W-1:0]       ax_q, ay_q;
	logic [2*ABS_W-1:0]     sq_x_q;
	logic [2*ABS_W-1:0]     sq_c;

	logic [RAD_W-1:0]       rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [MAG_W-1:0]       root_q;
	logic [STEP_W-1:0]      step_q;
	logic [REM_W+1:0]       rem_next;
	logic [REM_W+1:0]       trial;
	logic                   take;

	logic                   out_valid_q;
	logic [MAG_W-1:0]       out_mag_q;
	logic                   out_last_q;

	// Configuration registers; any write restarts the frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_REG_W'(WIDTH_RESET);
			image_height_q <= HEIGHT_W'(HEIGHT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the frame size to the supported range
	always_comb begin
		if (image_width_q < WIDTH_REG_W'(MIN_DIM)) begin
			eff_w = EWW'(MIN_DIM);
		end else if (int'(image_width_q) > MAX_WIDTH) begin
			eff_w = EWW'(MAX_WIDTH);
		end else begin
			eff_w = EWW'(image_width_q);
		end
		if (image_height_q < HEIGHT_W'(MIN_DIM)) begin
			eff_h = HEIGHT_W'(MIN_DIM);
		end else if (int'(image_height_q) > HEIGHT_LIMIT) begin
			eff_h = HEIGHT_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = image_height_q;
		end
	end

	// Current raster position and its successor
	assign row_ext     = HEIGHT_W'(row_q);
	assign col_cur     = (EWW'(column_q) >= eff_w) ? '0 : column_q;
	assign row_cur     = (row_ext >= eff_h) ? '0 : row_q;
	assign col_ext     = EWW'(col_cur);
	assign row_cur_ext = HEIGHT_W'(row_cur);
	assign col_inc     = col_ext + 1'b1;
	assign row_inc     = row_cur_ext + 1'b1;
	assign col_wrap    = col_inc >= eff_w;
	assign row_wrap    = row_inc >= eff_h;
	assign last_c      = (row_cur_ext == eff_h - 1'b1) && (col_ext == eff_w - 1'b1);

	assign st.produce  = (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (cmd.update) begin
			if (col_wrap) begin
				column_q <= '0;
				row_q    <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				column_q <= col_inc[CW-1:0];
				row_q    <= row_cur;
			end
		end
	end

	// Line stores: read at accept, write back during the window update
	pem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (col_cur),
		.wdata (middle_rd),
		.re    (cmd.load_px),
		.raddr (col_cur),
		.rdata (upper_rd)
	);

	pem_ram #(.WIDTH(PIXEL_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (col_cur),
		.wdata (pixel_q),
		.re    (cmd.load_px),
		.raddr (col_cur),
		.rdata (middle_rd)
	);

	// Window shift: left <- centre <- right <- new column
	always_ff @(posedge clk) begin
		if (cmd.load_px) begin
			pixel_q <= pixel;
		end
		if (cmd.update) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= upper_rd;
			win_q[1][2] <= middle_rd;
			win_q[2][2] <= pixel_q;
			last_q      <= last_c;
		end
	end

	// Gradients
	assign sum_l = SUM_W'(win_q[0][0]) + SUM_W'(win_q[1][0]) + SUM_W'(win_q[2][0]);
	assign sum_r = SUM_W'(win_q[0][2]) + SUM_W'(win_q[1][2]) + SUM_W'(win_q[2][2]);
	assign sum_t = SUM_W'(win_q[0][0]) + SUM_W'(win_q[0][1]) + SUM_W'(win_q[0][2]);
	assign sum_b = SUM_W'(win_q[2][0]) + SUM_W'(win_q[2][1]) + SUM_W'(win_q[2][2]);
	assign dx    = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
	assign dy    = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});

	// One squarer, shared by both gradients
	assign sq_c = cmd.sq_x ? ax_q * ax_q : ay_q * ay_q;

	// Square root, one result bit per step
	assign rem_next = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign take     = rem_next >= trial;

	always_ff @(posedge clk) begin
		if (cmd.grad) begin
			ax_q <= dx[SUM_W] ? ABS_W'(-dx) : dx[ABS_W-1:0];
			ay_q <= dy[SUM_W] ? ABS_W'(-dy) : dy[ABS_W-1:0];
		end
		if (cmd.sq_x) begin
			sq_x_q <= sq_c;
		end
		if (cmd.sq_y) begin
			rad_q  <= RAD_W'(sq_x_q) + RAD_W'(sq_c);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			rem_q  <= take ? REM_W'(rem_next - trial) : REM_W'(rem_next);
			root_q <= {root_q[MAG_W-2:0], take};
			rad_q  <= rad_q << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.sq_y) begin
			step_q <= '0;
		end else if (cmd.root_step) begin
			step_q <= step_q + 1'b1;
		end
	end

	assign st.root_last = (step_q == STEP_W'(ROOT_STEPS - 1));

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_mag_q  <= root_q;
			out_last_q <= last_q;
		end
	end

	assign st.out_free = !out_valid_q || m_tready;
	assign m_tvalid    = out_valid_q;
	assign m_tdata     = 16'(out_mag_q);
	assign m_tlast     = out_last_q;

	`PEM_ASSERT(a_col_in_range, EWW'(column_q) < eff_w, "column count past row width")
	`PEM_ASSERT(a_row_in_range, row_ext < eff_h, "row count past frame height")
	`PEM_ASSERT(a_load_needs_slot, !cmd.load_out || st.out_free, "output overwritten")

endmodule

>>> rtl/pem_ctrl.sv
// ----------------------------------------------------------------------------
// Prewitt edge magnitude controller
// Sequences one pixel through update, gradient, squares and root steps.
// ----------------------------------------------------------------------------
`include "prewitt_edge_magnitude_core_defines.svh"

module pem_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  pem_pkg::status_t st,
	output pem_pkg::cmd_t    cmd
);

	import pem_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_px = 1'b1;
					state_d     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = st.produce ? ST_GRAD : ST_IDLE;
			end
			ST_GRAD: begin
				cmd.grad = 1'b1;
				state_d  = ST_SQX;
			end
			ST_SQX: begin
				cmd.sq_x = 1'b1;
				state_d  = ST_SQY;
			end
			ST_SQY: begin
				cmd.sq_y = 1'b1;
				state_d  = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.root_step = 1'b1;
				if (st.root_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the result until the output register has room
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`PEM_ASSERT_NEXT(a_accept_updates, s_tvalid && s_tready, state_q == ST_UPDATE, "accept lost")
	`PEM_ASSERT_NEXT(a_root_ends, cmd.root_step && st.root_last, state_q == ST_DONE, "root overrun")
	`PEM_ASSERT_NEXT(a_load_returns, cmd.load_out, state_q == ST_IDLE, "no return to idle")

endmodule

>>> rtl/prewitt_edge_magnitude_core.sv
// ----------------------------------------------------------------------------
// Prewitt edge magnitude core
// 3x3 Prewitt gradient magnitude floor(sqrt(dx^2+dy^2)) over a raster pixel
// stream, one result per interior pixel, last result of a frame on tlast.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake           payload
//  s_axis    in   s_tvalid/s_tready   s_tdata[7:0] pixel
//  m_axis    out  m_tvalid/m_tready   m_tdata[10:0] magnitude, m_tlast frame_last
//  cfg       in   cfg_we              cfg_index, cfg_data
//
//  A pixel that makes no result (frame border) goes through accept with the
//  line store read, then the window update and line store write-back.
//  An interior pixel goes through the two above, gradient, two squarer
//  passes through one shared multiplier, 11 square root steps (one result bit
//  each) and the hand-off into the output register.
//  The output register parts the sides: the next pixel is taken while a result
//  waits; a result finished while the register is still full holds the core.
//  Reset clears control, counters and config; line stores start unknown and
//  take no clearing pass, since border rows and columns never read stale data.
//  A config write restarts the frame position and keeps stores and window.
//
module prewitt_edge_magnitude_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [pem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pem_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] pixel
	// magnitude stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,   // [10:0] magnitude, [15:11] zero
	output logic                           m_tlast    // frame_last
);

	import pem_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer: one pixel transaction at a time
	pem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Storage and arithmetic, driven by the sequencer commands
	pem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (s_tdata[PIXEL_W-1:0]),
		.cmd       (cmd),
		.st        (st),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

>>> tb/prewitt_edge_magnitude_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt edge magnitude checker
// Watches the config port and both streams, keeps its own line rows, window
// and frame position, and compares every magnitude transaction in order.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_core_checker
	import pem_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] pixel
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [15:0]           m_tdata,   // [10:0] magnitude, [15:11] zero
	input  logic                  m_tlast,   // frame_last
	output int                    fail_count,
	output int                    pending_results,
	output int                    magnitudes_checked,
	output int                    frame_ends
);

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             frame_last;
	} edge_result_t;

	logic [PIXEL_W-1:0]     upper_row [MAX_WIDTH];
	logic [PIXEL_W-1:0]     middle_row [MAX_WIDTH];
	logic [PIXEL_W-1:0]     taps [3][3];   // [top,mid,bottom][left,centre,right]
	logic [WIDTH_REG_W-1:0] width_reg;
	logic [HEIGHT_W-1:0]    height_reg;
	int unsigned            col_pos;
	int unsigned            row_pos;
	edge_result_t           expected_edges [$];

	function automatic int unsigned active_width();
		int unsigned w;
		w = width_reg;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned active_height();
		int unsigned h;
		h = height_reg;
		if (h < MIN_DIM) h = MIN_DIM;
		if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
		return h;
	endfunction

	// Bitwise search from the top: keep a bit when the square stays in range.
	function automatic logic [MAG_W-1:0] floor_root(input int unsigned value);
		logic [MAG_W-1:0] root;
		logic [MAG_W-1:0] trial;
		root = '0;
		for (int b = MAG_W - 1; b >= 0; b--) begin
			trial = root | (MAG_W'(1) << b);
			if (int'(trial) * int'(trial) <= value) root = trial;
		end
		return root;
	endfunction

	task automatic take_pixel(input logic [PIXEL_W-1:0] px);
		int unsigned  w;
		int unsigned  h;
		int unsigned  c;
		int unsigned  r;
		int           t [3][3];
		int           dx;
		int           dy;
		edge_result_t res;
		w = active_width();
		h = active_height();
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		for (int k = 0; k < 3; k++) begin
			taps[k][0] = taps[k][1];
			taps[k][1] = taps[k][2];
		end
		taps[0][2] = upper_row[c];
		taps[1][2] = middle_row[c];
		taps[2][2] = px;
		upper_row[c] = middle_row[c];
		middle_row[c] = px;
		if (r >= 2 && c >= 2) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					t[i][j] = taps[i][j];
			dx = t[0][0] + t[1][0] + t[2][0] - t[0][2] - t[1][2] - t[2][2];
			dy = t[0][0] + t[0][1] + t[0][2] - t[2][0] - t[2][1] - t[2][2];
			res.magnitude = floor_root(dx * dx + dy * dy);
			res.frame_last = (r == h - 1) && (c == w - 1);
			expected_edges.push_back(res);
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		edge_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					taps[i][j] = '0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col_pos = 0;
			row_pos = 0;
			expected_edges.delete();
			fail_count = 0;
			magnitudes_checked = 0;
			frame_ends = 0;
			pending_results <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_reg = cfg_data[WIDTH_REG_W-1:0];
					CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
				col_pos = 0;
				row_pos = 0;
			end
			if (s_tvalid && s_tready) take_pixel(s_tdata[PIXEL_W-1:0]);
			if (m_tvalid && m_tready) begin
				if (expected_edges.size() == 0) begin
					fail_count++;
					$error("magnitude %0d arrived with no pixel expecting one",
						m_tdata[MAG_W-1:0]);
				end else begin
					want = expected_edges.pop_front();
					magnitudes_checked++;
					if (want.frame_last) frame_ends++;
					if (m_tdata[MAG_W-1:0] !== want.magnitude) begin
						fail_count++;
						$error("magnitude mismatch: expected %0d, got %0d",
							want.magnitude, m_tdata[MAG_W-1:0]);
					end
					if (m_tlast !== want.frame_last) begin
						fail_count++;
						$error("frame_last mismatch: expected %0b, got %0b",
							want.frame_last, m_tlast);
					end
					if (m_tdata[15:MAG_W] !== '0) begin
						fail_count++;
						$error("tdata padding mismatch: expected 0, got %0h",
							m_tdata[15:MAG_W]);
					end
				end
			end
			pending_results <= expected_edges.size();
		end
	end

endmodule

>>> tb/prewitt_edge_magnitude_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prewitt edge magnitude core test
// Streams raster frames of many geometries into the core, with random gaps on
// the pixel side and random stalls on the magnitude side; a checker beside the
// core predicts every magnitude and frame end and counts the mismatches.
// ----------------------------------------------------------------------------
module prewitt_edge_magnitude_core_test;

	import pem_pkg::*;

	localparam int MAX_WIDTH        = 1024;
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int SETTLE_CYCLES    = 24;    // outlasts a border pixel and a whole result
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int RANDOM_PIXELS    = 180;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;     // [7:0] pixel
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;          // [10:0] magnitude, [15:11] zero
	logic                  m_tlast;          // frame_last

	int     fail_count;
	int     pending_results;
	int     magnitudes_checked;
	int     frame_ends;
	int     sender_idle_pct = 37;
	int     receiver_idle_pct = 79;
	int     hold_requests = 0;
	int     hold_grants = 0;
	int     hold_left = 0;
	int     pixels_sent = 0;
	int     settings_used = 0;
	longint cycle_count = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	prewitt_edge_magnitude_core #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	prewitt_edge_magnitude_core_checker #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tlast            (m_tlast),
		.fail_count         (fail_count),
		.pending_results    (pending_results),
		.magnitudes_checked (magnitudes_checked),
		.frame_ends         (frame_ends)
	);

	// Magnitude side: random stalls, or a long hold-off when one is requested.
	// During the hold the output register fills and the core must drop s_tready.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_grants != hold_requests) begin
			hold_grants <= hold_requests;
			hold_left <= LONG_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Watchdog: end the run if the core never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d magnitudes outstanding",
				cycle_count, pending_results);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Write one register; the trailing wait keeps back-to-back writes from
	// stacking two assignments to cfg_we in one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one pixel, idling first at the current rate; hold tvalid high
	// between back-to-back transactions.
	task automatic send_pixel(input logic [7:0] px);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_sent++;
	endtask

	// Drop tvalid, wait for every predicted magnitude, then let a trailing
	// border pixel finish before anything touches the registers.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly random intensities, with the extremes weighted up.
	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic run_frame_phase(input logic [CFG_DATA_W-1:0] width_val,
			input logic [CFG_DATA_W-1:0] height_val, input int n_pixels);
		write_reg(CFG_IMAGE_WIDTH, width_val);
		write_reg(CFG_IMAGE_HEIGHT, height_val);
		settings_used++;
		repeat (n_pixels) send_pixel(pick_pixel());
		drain();
	endtask

	// Small random geometry; the pixel count rarely lands on a frame boundary,
	// so the next register write restarts the core mid-frame.
	task automatic run_random_phase();
		int                    cols;
		int                    rows;
		int                    frame_px;
		logic [CFG_DATA_W-1:0] width_val;
		logic [CFG_DATA_W-1:0] height_val;
		cols = $urandom_range(3, 12);
		rows = $urandom_range(3, 7);
		// bits above the width register are junk the core must ignore
		width_val = {2'($urandom_range(3)), 11'(cols)};
		height_val = 13'(rows);
		// codes below three still mean three
		if (cols == 3 && $urandom_range(1) == 1) width_val[10:0] = 11'($urandom_range(2));
		if (rows == 3 && $urandom_range(1) == 1) height_val = 13'($urandom_range(2));
		frame_px = cols * rows;
		run_frame_phase(width_val, height_val, $urandom_range(frame_px / 2, 3 * frame_px));
	endtask

	// Two back-to-back 3x3 frames: strong vertical-plus-horizontal edge, then
	// a pure vertical edge at full swing. Each yields one result marked last.
	logic [7:0] edge_frames [18] = '{
		8'd255, 8'd255, 8'd255,
		8'd255, 8'd128, 8'd0,
		8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd255,
		8'd0,   8'd0,   8'd255,
		8'd0,   8'd0,   8'd255
	};

	initial begin
		int mode_start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: width and height codes below the minimum give a 3x3 frame.
		write_reg(CFG_IMAGE_WIDTH, 13'd2);
		write_reg(CFG_IMAGE_HEIGHT, 13'd0);
		settings_used++;
		foreach (edge_frames[i]) send_pixel(edge_frames[i]);
		drain();
		// Exact minimum, several whole frames so the position wraps.
		run_frame_phase(13'd3, 13'd3, 27);

		// Random part in three idling regimes.
		for (int mode = 0; mode < 3; mode++) begin
			sender_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 79 : 0;
			receiver_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 37 : 0;
			mode_start = pixels_sent;
			if (mode == 2) begin
				// Hold the magnitude side off while pixels keep coming.
				hold_requests++;
				run_frame_phase(13'd5, 13'd5, 60);
				// All-ones codes clamp to the widest row and the tallest frame;
				// a short run stays in the top border rows.
				run_frame_phase(13'h1FFF, 13'h1FFF, 40);
				// Widest row exactly, height one past the limit.
				run_frame_phase(13'(MAX_WIDTH), 13'(HEIGHT_LIMIT + 1), 40);
				mode_start = pixels_sent;
			end
			while (pixels_sent - mode_start < RANDOM_PIXELS / 3) run_random_phase();
		end

		$display("Run covered %0d pixels over %0d geometries, min to max, clamped both ways;",
			pixels_sent, settings_used);
		$display("%0d magnitudes compared, %0d frame ends seen, with gaps and a long stall.",
			magnitudes_checked, frame_ends);
		if (fail_count == 0 && pending_results == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
